[hw/rtl/dle_pkg.sv]
// ----------------------------------------------------------------------------
// dle_pkg : shared definitions for the DLE/ETX frame deframer
// Character codes, default sizing, controller states and the command and
// status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package dle_pkg;

    localparam logic [7:0] DLE_CODE = 8'h10;
    localparam logic [7:0] ETX_CODE = 8'h03;
    localparam logic [7:0] ESC_CODE = 8'h17;

    localparam int DEF_BUFFER_BYTES = 34;

    // register word index on the configuration port
    localparam logic REG_ESC_FIX = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_LOAD
    } dle_state_t;

    typedef struct packed {
        logic step;       // take one received byte
        logic pend_wr;    // perform the deferred store write
        logic load_out;   // fill the output register
        logic next_byte;  // advance the drain pointer
    } dle_cmd_t;

    typedef struct packed {
        logic step_copy;  // this byte needs a second store write
        logic step_done;  // this byte closes a frame
        logic step_empty; // closing frame has no body
        logic pend_done;  // deferred write belongs to a closing byte
        logic size_zero;  // registered frame length is zero
        logic at_last;    // drain pointer on the final byte
        logic out_free;   // output register can take a new transfer
    } dle_status_t;

endpackage

[hw/rtl/dle_etx_frame_deframer.sv]
// ----------------------------------------------------------------------------
// dle_etx_frame_deframer : DLE/ETX byte-stuffed frame deframer
// Finds ETX DLE id ... DLE ETX frames in a byte stream and emits the
// unstuffed frame body as a run of output transfers.
// ----------------------------------------------------------------------------
// A received byte is normally taken in ST_IDLE alone. The second byte
// after a frame's id also passes through ST_WRITE, since the store has
// one write port and that byte writes it twice (id copy plus its own
// deferred byte); when the id is a swallowed escape there is no copy
// and no ST_WRITE. When a byte closes a frame, the body is drained from
// the frame store one output transfer at a time, each body byte through
// ST_READ (the registered store read) and ST_LOAD (loading the output
// register), waiting in ST_LOAD while the output side is stalled. An empty
// frame gives a single transfer marked last and empty. in_stall is high
// while a write or drain is in progress; the final transfer of a frame
// may still sit in the output register while the next byte is taken.
// Body length is capped at BUFFER_BYTES-2; a frame that fills the store
// is dropped unless it closes on that same byte. The escape fix bit
// (register 0, bit 0) drops a leading 0x17 id byte. No clearing pass.
// ----------------------------------------------------------------------------
module dle_etx_frame_deframer
#(
    parameter int BUFFER_BYTES = dle_pkg::DEF_BUFFER_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,

    // received byte stream
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    // frame body output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    output logic        empty_frame,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dle_pkg::dle_cmd_t    cmd;
    dle_pkg::dle_status_t status;
    logic                 esc_fix_enable;

    // register bank
    dle_cfg u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .esc_fix_enable (esc_fix_enable)
    );

    // sequencer: intake, deferred write, drain
    dle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // frame detection, store and output register
    dle_dpath
    #(
        .BUFFER_BYTES (BUFFER_BYTES)
    )
    u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .esc_fix_enable (esc_fix_enable),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_byte     (frame_byte),
        .last_byte      (last_byte),
        .empty_frame    (empty_frame)
    );

endmodule

[hw/rtl/dle_cfg.sv]
// ----------------------------------------------------------------------------
// dle_cfg : configuration register bank
// APB-style slave holding the escape fix enable bit.
// ----------------------------------------------------------------------------
module dle_cfg
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        esc_fix_enable
);

    logic esc_fix_reg;
    logic esc_fix_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == dle_pkg::REG_ESC_FIX);

    always_comb
    begin
        esc_fix_next = esc_fix_reg;
        if (wr_en)
        begin
            esc_fix_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_fix_reg <= 1'b0;
        end
        else
        begin
            esc_fix_reg <= esc_fix_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == dle_pkg::REG_ESC_FIX)
        begin
            prdata = {31'd0, esc_fix_reg};
        end
    end

    assign esc_fix_enable = esc_fix_reg;

endmodule

[hw/rtl/dle_dpath.sv]
// ----------------------------------------------------------------------------
// dle_dpath : deframer datapath
// Frame detection, stuffing removal, frame store and output register.
// ----------------------------------------------------------------------------
module dle_dpath
#(
    parameter int BUFFER_BYTES = dle_pkg::DEF_BUFFER_BYTES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dle_pkg::dle_cmd_t   cmd,
    output dle_pkg::dle_status_t status,
    input  logic                esc_fix_enable,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          frame_byte,
    output logic                last_byte,
    output logic                empty_frame
);

    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam int IW = $clog2(BUFFER_BYTES);
    localparam logic [FW-1:0] FILL_LIMIT = FW'(BUFFER_BYTES);

    // frame store, single write port, registered read
    logic [7:0] store_mem [BUFFER_BYTES];

    logic [FW-1:0] fill_reg, fill_next;
    logic          in_frame_reg, in_frame_next;
    logic          parity_reg, parity_next;
    logic [7:0]    prev_reg, prev_next;
    logic [7:0]    prev2_reg, prev2_next;
    logic [7:0]    id_reg;
    logic [7:0]    pend_data_reg;
    logic [IW-1:0] pend_idx_reg;
    logic          done_reg;
    logic [FW-1:0] size_reg;
    logic [FW-1:0] rd_idx_reg;
    logic [7:0]    rdata_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic          out_empty_reg;

    logic          copy_now;
    logic [FW-1:0] fill_a;
    logic [FW-1:0] fill_b;
    logic [FW-1:0] fill_c;
    logic          par_n;
    logic          done_now;
    logic [FW-1:0] size_now;
    logic          start_now;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [7:0]    wr_data;

    always_comb
    begin
        copy_now = in_frame_reg && (fill_reg == FW'(1))
                   && !((id_reg == dle_pkg::ESC_CODE) && esc_fix_enable);
        fill_a   = copy_now ? FW'(2) : fill_reg;
        fill_b   = fill_a + FW'(1);
        par_n    = (rx_byte == dle_pkg::DLE_CODE) ? !parity_reg : parity_reg;
        // first DLE of a doubled pair is dropped
        fill_c   = ((rx_byte == dle_pkg::DLE_CODE) && par_n) ? fill_b - FW'(1) : fill_b;
        done_now = in_frame_reg && (rx_byte == dle_pkg::ETX_CODE)
                   && (prev_reg == dle_pkg::DLE_CODE) && !par_n;
        size_now = (fill_c >= FW'(2)) ? fill_c - FW'(2) : '0;
        start_now = !in_frame_reg && (rx_byte != dle_pkg::DLE_CODE)
                    && (rx_byte != dle_pkg::ETX_CODE)
                    && (prev_reg == dle_pkg::DLE_CODE)
                    && (prev2_reg == dle_pkg::ETX_CODE);
    end

    always_comb
    begin
        fill_next     = fill_reg;
        in_frame_next = in_frame_reg;
        parity_next   = parity_reg;
        prev_next     = prev_reg;
        prev2_next    = prev2_reg;
        if (cmd.step)
        begin
            prev_next  = rx_byte;
            prev2_next = prev_reg;
            if (in_frame_reg)
            begin
                fill_next     = fill_c;
                parity_next   = par_n;
                in_frame_next = (fill_b < FILL_LIMIT) && !done_now;
            end
            else if (start_now)
            begin
                in_frame_next = 1'b1;
                fill_next     = '0;
                parity_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            in_frame_reg <= 1'b0;
            parity_reg   <= 1'b0;
            prev_reg     <= dle_pkg::ETX_CODE;
            prev2_reg    <= dle_pkg::DLE_CODE;
        end
        else
        begin
            fill_reg     <= fill_next;
            in_frame_reg <= in_frame_next;
            parity_reg   <= parity_next;
            prev_reg     <= prev_next;
            prev2_reg    <= prev2_next;
        end
    end

    // store write select: the id copy goes first, the deferred byte after
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = pend_idx_reg;
        wr_data = pend_data_reg;
        if (cmd.pend_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.step && in_frame_reg)
        begin
            wr_en   = 1'b1;
            wr_idx  = copy_now ? IW'(1) : fill_a[IW-1:0];
            wr_data = copy_now ? id_reg : prev_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_idx] <= wr_data;
        end
        rdata_reg <= store_mem[rd_idx_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            if (in_frame_reg && (fill_reg == '0))
            begin
                id_reg <= prev_reg;
            end
            pend_data_reg <= prev_reg;
            pend_idx_reg  <= fill_a[IW-1:0];
            done_reg      <= done_now;
            size_reg      <= size_now;
            rd_idx_reg    <= FW'(1);
        end
        else if (cmd.next_byte)
        begin
            rd_idx_reg <= rd_idx_reg + FW'(1);
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_byte_reg  <= (size_reg == '0) ? 8'd0 : rdata_reg;
            out_last_reg  <= (size_reg == '0) || (rd_idx_reg == size_reg);
            out_empty_reg <= (size_reg == '0);
        end
    end

    assign status.step_copy  = copy_now;
    assign status.step_done  = done_now;
    assign status.step_empty = (size_now == '0);
    assign status.pend_done  = done_reg;
    assign status.size_zero  = (size_reg == '0);
    assign status.at_last    = (rd_idx_reg == size_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign frame_byte  = out_byte_reg;
    assign last_byte   = out_last_reg;
    assign empty_frame = out_empty_reg;

endmodule

[hw/rtl/dle_ctrl.sv]
// ----------------------------------------------------------------------------
// dle_ctrl : deframer controller
// Sequences byte intake, the deferred store write and the frame drain.
// ----------------------------------------------------------------------------
module dle_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dle_pkg::dle_status_t status,
    output dle_pkg::dle_cmd_t    cmd
);

    dle_pkg::dle_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dle_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != dle_pkg::ST_IDLE);
        unique case (state_reg)
            dle_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step = 1'b1;
                    if (status.step_copy)
                    begin
                        state_next = dle_pkg::ST_WRITE;
                    end
                    else if (status.step_done)
                    begin
                        state_next = status.step_empty ? dle_pkg::ST_LOAD
                                                       : dle_pkg::ST_READ;
                    end
                end
            end
            dle_pkg::ST_WRITE:
            begin
                cmd.pend_wr = 1'b1;
                if (status.pend_done)
                begin
                    state_next = status.size_zero ? dle_pkg::ST_LOAD : dle_pkg::ST_READ;
                end
                else
                begin
                    state_next = dle_pkg::ST_IDLE;
                end
            end
            dle_pkg::ST_READ:
            begin
                state_next = dle_pkg::ST_LOAD;
            end
            dle_pkg::ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.size_zero || status.at_last)
                    begin
                        state_next = dle_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_byte = 1'b1;
                        state_next    = dle_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = dle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[tb/sv/dle_deframer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dle_deframer_checker : frame body predictor and scoreboard
// Watches the byte input, the frame output and configuration writes; keeps
// its own copy of the deframer state, queues the body bytes each received
// byte should release and compares every output transfer against them.
// ----------------------------------------------------------------------------
module dle_deframer_checker
    import dle_pkg::*;
#(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    input  logic        empty_frame,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          outstanding
);

    localparam logic [2:0] ESC_FIX_ADDR = {REG_ESC_FIX, 2'b00};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } body_item_t;

    body_item_t  body_q[$];

    // shadow of the deframer state
    logic [7:0]  store [BUFFER_BYTES];
    int unsigned fill;
    bit          in_frame;
    bit          parity;
    logic [7:0]  prev;
    logic [7:0]  prev2;
    bit          esc_fix;

    // one received byte: update the shadow state, queue any released body
    task automatic deframe_byte(input logic [7:0] c);
        bit          done;
        int unsigned size;
        body_item_t  item;
        done = 1'b0;
        size = 0;
        if (in_frame)
        begin
            // second visit: id copied forward unless it is a swallowed escape
            if (fill == 1 && (store[0] != ESC_CODE || !esc_fix))
            begin
                store[1] = store[0];
                fill     = 2;
            end
            if (fill < BUFFER_BYTES)
                store[fill] = prev;
            fill++;
            if (fill >= BUFFER_BYTES)
                in_frame = 1'b0;
            if (c == DLE_CODE)
            begin
                parity = !parity;
                if (parity && fill > 0)
                    fill--;
            end
            if (c == ETX_CODE && prev == DLE_CODE && !parity)
            begin
                done     = 1'b1;
                size     = (fill >= 2) ? fill - 2 : 0;
                in_frame = 1'b0;
            end
            if (done)
            begin
                if (size == 0)
                begin
                    item = '{data: 8'h00, last: 1'b1, empty: 1'b1};
                    body_q.push_back(item);
                end
                else
                begin
                    for (int k = 0; k < size; k++)
                    begin
                        item = '{data: store[1 + k], last: (k + 1 == size), empty: 1'b0};
                        body_q.push_back(item);
                    end
                end
            end
        end
        else if (c != DLE_CODE && c != ETX_CODE && prev == DLE_CODE && prev2 == ETX_CODE)
        begin
            in_frame = 1'b1;
            fill     = 0;
            parity   = 1'b1;
        end
        prev2 = prev;
        prev  = c;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        body_item_t want;
        if (!rst_n)
        begin
            body_q.delete();
            for (int i = 0; i < BUFFER_BYTES; i++)
                store[i] = 8'h00;
            fill        = 0;
            in_frame    = 1'b0;
            parity      = 1'b0;
            prev        = ETX_CODE;
            prev2       = DLE_CODE;
            esc_fix     = 1'b0;
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ESC_FIX_ADDR)
                esc_fix = pwdata[0];

            if (in_valid && !in_stall)
                deframe_byte(rx_byte);

            if (out_valid && !out_stall)
            begin
                if (body_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transfer: byte %02h last %b empty %b",
                                 frame_byte, last_byte, empty_frame);
                end
                else
                begin
                    want = body_q.pop_front();
                    if (frame_byte !== want.data || last_byte !== want.last ||
                        empty_frame !== want.empty)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp byte %02h last %b empty %b, got %02h %b %b",
                                     want.data, want.last, want.empty,
                                     frame_byte, last_byte, empty_frame);
                    end
                end
            end
            outstanding = body_q.size();
        end
    end

endmodule

[tb/sv/tb_dle_etx_frame_deframer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dle_etx_frame_deframer : stimulus and verdict for the frame deframer
// Drives a byte stream of well-formed, stuffed frames mixed with noise and
// broken frames, under random input gaps and output stalls, across both
// settings of the escape fix bit. Checking is left to the checker module.
// ----------------------------------------------------------------------------
module tb_dle_etx_frame_deframer;

    import dle_pkg::*;

    localparam int          BUFFER_BYTES = DEF_BUFFER_BYTES;
    localparam logic [2:0]  ESC_FIX_ADDR = {REG_ESC_FIX, 2'b00};
    // settle time before a register write: the second byte after an id
    // also passes through a second store write, which yields no transfer
    localparam int          SETTLE_CYCLES = 8;
    // a full body drains through a store read and an output load per transfer
    localparam int          DRAIN_CYCLES  = 2 * BUFFER_BYTES + 16;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          PHASE_BYTES   = 55;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        empty_frame;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          outstanding;
    int          cycle_count = 0;
    int          frame_bytes = 0;   // bytes sent as part of frames, noise excluded
    int          stall_left  = 0;
    bit          gaps_on     = 1'b1;
    logic [7:0]  body_buf [64];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dle_etx_frame_deframer #(.BUFFER_BYTES(BUFFER_BYTES)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .empty_frame(empty_frame),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    dle_deframer_checker #(.BUFFER_BYTES(BUFFER_BYTES)) deframe_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .empty_frame(empty_frame),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .errors     (errors),
        .outstanding(outstanding)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // output side back-pressure: random stall bursts of random length,
    // switched off together with the input gaps for the final phase
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_left <= 0;
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 16);
        end
    end

    // one byte transfer; valid stays high into the next call unless a gap
    // is taken, so back-to-back bytes never see valid dropped and re-raised
    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
    endtask

    // ETX DLE id body DLE ETX, body taken from body_buf; with stuff clear
    // a data DLE goes out single, and with close clear the trailer is cut
    task automatic send_frame(input logic [7:0] id, input int len,
                              input bit close, input bit stuff);
        send_byte(ETX_CODE);
        send_byte(DLE_CODE);
        send_byte(id);
        frame_bytes += 3;
        for (int i = 0; i < len; i++)
        begin
            send_byte(body_buf[i]);
            frame_bytes++;
            if (body_buf[i] == DLE_CODE && stuff)
            begin
                send_byte(DLE_CODE);
                frame_bytes++;
            end
        end
        if (close)
        begin
            send_byte(DLE_CODE);
            send_byte(ETX_CODE);
            frame_bytes += 2;
        end
    endtask

    // sender holds off until every predicted transfer has been taken;
    // sampled at clock edges, where a stale count can only read high
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // register write in setup and access phases; the block is idle here
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_escape_fix(input bit on);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        reg_write(ESC_FIX_ADDR, {31'd0, on});
    endtask

    // random frame: mostly short bodies, some near or over store capacity,
    // id biased towards the escape code, DLE and ETX, and the extremes
    task automatic send_random_frame(input int forced_len);
        int unsigned pick;
        logic [7:0]  id;
        int          len;
        logic [7:0]  noise;
        pick = $urandom_range(0, 15);
        if (pick < 3)
            id = ESC_CODE;
        else if (pick == 3)
            id = $urandom_range(0, 1) ? DLE_CODE : ETX_CODE;
        else if (pick == 4)
            id = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
        else
            id = 8'($urandom_range(0, 255));
        if (forced_len >= 0)
            len = forced_len;
        else if ($urandom_range(0, 7) == 0)
            len = $urandom_range(BUFFER_BYTES - 6, BUFFER_BYTES - 1);
        else
            len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 23);
            if (pick < 4)
                body_buf[i] = DLE_CODE;
            else if (pick < 6)
                body_buf[i] = ETX_CODE;
            else if (pick == 6)
                body_buf[i] = ESC_CODE;
            else
                body_buf[i] = 8'($urandom_range(0, 255));
        end
        // line noise between frames, rich in the control codes
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                pick = $urandom_range(0, 3);
                noise = (pick == 0) ? DLE_CODE : (pick == 1) ? ETX_CODE :
                        (pick == 2) ? ESC_CODE : 8'($urandom_range(0, 255));
                send_byte(noise);
            end
        end
        send_frame(id, len, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 11) == 0)
            wait_for_results();
    endtask

    // random phase; the first frame closes on the byte that fills the
    // store (for a non-escape id, closed and stuffed), so the full-store
    // close is hit in most phases
    task automatic random_phase(input bit esc_on);
        int start;
        set_escape_fix(esc_on);
        start = frame_bytes;
        send_random_frame(BUFFER_BYTES - 3);
        while (frame_bytes - start < PHASE_BYTES)
            send_random_frame(-1);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, escape fix off: extreme id and body values, then a
        // stuffed DLE followed by a body ETX that must not close the frame
        reg_write(ESC_FIX_ADDR, 32'd0);
        body_buf[0] = 8'h00;
        send_frame(8'hFF, 1, 1'b1, 1'b1);
        body_buf[0] = DLE_CODE;
        body_buf[1] = ETX_CODE;
        send_frame(8'h41, 2, 1'b1, 1'b1);

        // directed, escape fix on: swallowed escape id gives an empty
        // frame, and with one body byte only that byte comes out
        set_escape_fix(1'b1);
        send_frame(ESC_CODE, 0, 1'b1, 1'b1);
        body_buf[0] = 8'h55;
        send_frame(ESC_CODE, 1, 1'b1, 1'b1);

        random_phase(1'b0);
        random_phase(1'b1);
        random_phase(1'b0);
        // final phase runs flat out, no gaps and no stalls
        wait_for_results();
        gaps_on = 1'b0;
        random_phase(1'b1);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
